// ----- sv/latched_roll_stick_rotator_assert.svh -----
`ifndef LATCHED_ROLL_STICK_ROTATOR_ASSERT_SVH
`define LATCHED_ROLL_STICK_ROTATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LRSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lrsr_pkg.sv -----
package lrsr_pkg;

  localparam int ANGLE_BITS_DEF      = 16;
  localparam int STICK_FRAC_BITS_DEF = 14;

  localparam int AXIS_W  = 16;   // stick and result fields
  localparam int ROLL_W  = 16;   // roll field
  localparam int TURN_W  = 32;   // binary angle inside the rotator
  localparam int CS_W    = 32;   // cosine / sine, Q2.30
  localparam int CS_FRAC = 30;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [CS_W-1:0] CORDIC_START = 32'sd652032874;

  // arctan(2^-i) in 2^32 units per turn
  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_SELECT = 1'd1;

  typedef struct packed {
    logic signed [AXIS_W-1:0] stick_yaw;
    logic signed [AXIS_W-1:0] stick_pitch;
    logic signed [ROLL_W-1:0] roll_angle;
    logic                     handbrake;
    logic                     boost;
  } lrsr_in_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] out_yaw;
    logic signed [AXIS_W-1:0] out_pitch;
    logic                     locked;
  } lrsr_out_t;

  // What one rotator cell hands to the next
  typedef struct packed {
    logic signed [CS_W-1:0]   x;
    logic signed [CS_W-1:0]   y;
    logic signed [TURN_W-1:0] z;
    logic signed [AXIS_W-1:0] yaw;
    logic signed [AXIS_W-1:0] pitch;
    logic                     locked;
    logic                     flip;
  } lrsr_cell_t;

endpackage

// ----- sv/lrsr_front.sv -----
`include "latched_roll_stick_rotator_assert.svh"

module lrsr_front #(
  parameter int ANGLE_BITS = lrsr_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lrsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrsr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lrsr_pkg::lrsr_in_t               in_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output lrsr_pkg::lrsr_cell_t             dn_data
);
  import lrsr_pkg::*;

  logic                  enable_r;
  logic                  sel_r;
  logic                  lock_on_r, lock_nxt;
  logic [ANGLE_BITS-1:0] held_roll_r, held_nxt;
  logic                  valid_r;
  lrsr_cell_t            data_r, data_nxt;

  logic                  acc;
  logic                  lock_clr;
  logic                  pressed;
  logic [TURN_W-1:0]     roll_ext;
  logic [ANGLE_BITS-1:0] roll_a;
  logic [ANGLE_BITS-1:0] diff;
  logic [TURN_W-1:0]     turn;
  logic                  flip;

  assign in_ready = !valid_r || dn_ready;
  assign acc      = in_valid && in_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // a write of zero to enable drops the lock at once
  assign lock_clr = cfg_we && (cfg_index == CFG_ENABLE) && !cfg_data[0];

  assign roll_ext = {{(TURN_W-ROLL_W){in_data.roll_angle[ROLL_W-1]}}, in_data.roll_angle};
  assign roll_a   = roll_ext[ANGLE_BITS-1:0];
  assign pressed  = sel_r ? in_data.boost : in_data.handbrake;

  always_comb begin
    lock_nxt = lock_on_r;
    held_nxt = held_roll_r;
    if (!enable_r) begin
      lock_nxt = 1'b0;
    end else if (pressed && !lock_on_r) begin
      held_nxt = roll_a;
      lock_nxt = 1'b1;
    end else if (!pressed && lock_on_r) begin
      lock_nxt = 1'b0;
    end
    diff = roll_a - held_nxt;
    turn = {diff, {(TURN_W-ANGLE_BITS){1'b0}}};
    // fold the angle into the right half plane, negate the result later
    flip = turn[TURN_W-1] ^ turn[TURN_W-2];
    data_nxt.x      = CORDIC_START;
    data_nxt.y      = '0;
    data_nxt.z      = signed'(turn ^ {flip, {(TURN_W-1){1'b0}}});
    data_nxt.yaw    = in_data.stick_yaw;
    data_nxt.pitch  = in_data.stick_pitch;
    data_nxt.locked = lock_nxt;
    data_nxt.flip   = flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      sel_r       <= 1'b0;
      lock_on_r   <= 1'b0;
      held_roll_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (acc) begin
        held_roll_r <= held_nxt;
      end
      if (lock_clr) begin
        lock_on_r <= 1'b0;
      end else if (acc) begin
        lock_on_r <= lock_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: begin
            enable_r <= cfg_data[0];
          end
          CFG_BUTTON_SELECT: begin
            sel_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      data_r <= data_nxt;
    end
  end

  `LRSR_ASSERT_IMP(a_disabled_unlocked, !enable_r, !lock_on_r, "lock set while disabled")
  `LRSR_ASSERT_NXT(a_capture, acc && enable_r && pressed && !lock_on_r && !cfg_we, lock_on_r && held_roll_r == $past(roll_a), "press edge did not capture roll")

endmodule

// ----- sv/lrsr_cell.sv -----
module lrsr_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  lrsr_pkg::lrsr_cell_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output lrsr_pkg::lrsr_cell_t dn_data
);
  import lrsr_pkg::*;

  localparam logic signed [TURN_W-1:0] ANGLE = signed'(ATAN_TURNS[STEP]);

  logic                     valid_r;
  lrsr_cell_t               data_r, data_nxt;
  logic signed [CS_W-1:0]   x_s, y_s, dx, dy;
  logic signed [TURN_W-1:0] z_s;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // one micro-rotation: steer toward zero residual angle
  always_comb begin
    x_s      = up_data.x;
    y_s      = up_data.y;
    z_s      = up_data.z;
    dx       = y_s >>> STEP;
    dy       = x_s >>> STEP;
    data_nxt = up_data;
    if (!z_s[TURN_W-1]) begin
      data_nxt.x = x_s - dx;
      data_nxt.y = y_s + dy;
      data_nxt.z = z_s - ANGLE;
    end else begin
      data_nxt.x = x_s + dx;
      data_nxt.y = y_s - dy;
      data_nxt.z = z_s + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/lrsr_mix.sv -----
`include "latched_roll_stick_rotator_assert.svh"

module lrsr_mix #(
  parameter int STICK_FRAC_BITS = lrsr_pkg::STICK_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  lrsr_pkg::lrsr_cell_t up_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lrsr_pkg::lrsr_out_t  out_data
);
  import lrsr_pkg::*;

  localparam int OPD_W    = AXIS_W + 1;
  localparam int PROD_W   = OPD_W + CS_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int ONE      = 1 << STICK_FRAC_BITS;
  localparam int AXIS_MAX = (1 << (AXIS_W - 1)) - 1;
  localparam int AXIS_MIN = -(1 << (AXIS_W - 1));
  localparam int POS_LIM  = (ONE < AXIS_MAX) ? ONE : AXIS_MAX;
  localparam int NEG_LIM  = (-ONE > AXIS_MIN) ? -ONE : AXIS_MIN;
  localparam logic signed [SUM_W-1:0]  POS_LIM_W = SUM_W'(POS_LIM);
  localparam logic signed [SUM_W-1:0]  NEG_LIM_W = SUM_W'(NEG_LIM);
  localparam logic signed [AXIS_W-1:0] POS_LIM_A = AXIS_W'(POS_LIM);
  localparam logic signed [AXIS_W-1:0] NEG_LIM_A = AXIS_W'(NEG_LIM);
  localparam logic signed [SUM_W-1:0]  RND_HALF  = SUM_W'(1) << (CS_FRAC - 1);

  function automatic logic signed [AXIS_W-1:0] clamp_axis(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > POS_LIM_W) begin
      r = POS_LIM_W;
    end else if (v < NEG_LIM_W) begin
      r = NEG_LIM_W;
    end
    return r[AXIS_W-1:0];
  endfunction

  // product stage
  logic                     p_valid_r;
  logic signed [PROD_W-1:0] p_yc_r, p_ps_r, p_ys_r, p_pc_r;
  logic signed [AXIS_W-1:0] p_yaw_r, p_pitch_r;
  logic                     p_locked_r;
  logic                     p_ready;

  logic signed [OPD_W-1:0]  yaw_x, pitch_x, yaw_m, pitch_m;
  logic signed [CS_W-1:0]   c_s, s_s;
  logic signed [PROD_W-1:0] yc_nxt, ps_nxt, ys_nxt, pc_nxt;

  // output stage
  logic                     o_valid_r;
  lrsr_out_t                o_r, o_nxt;
  logic                     o_ready;
  logic signed [SUM_W-1:0]  sum_y, sum_p, sh_y, sh_p;

  assign o_ready  = !o_valid_r || out_ready;
  assign p_ready  = !p_valid_r || o_ready;
  assign up_ready = p_ready;

  // negating the stick operand stands in for negating cosine and sine
  always_comb begin
    c_s     = up_data.x;
    s_s     = up_data.y;
    yaw_x   = OPD_W'(up_data.yaw);
    pitch_x = OPD_W'(up_data.pitch);
    yaw_m   = up_data.flip ? -yaw_x : yaw_x;
    pitch_m = up_data.flip ? -pitch_x : pitch_x;
    yc_nxt  = yaw_m * c_s;
    ps_nxt  = pitch_m * s_s;
    ys_nxt  = yaw_m * s_s;
    pc_nxt  = pitch_m * c_s;
  end

  always_comb begin
    sum_y = SUM_W'(p_yc_r) - SUM_W'(p_ps_r) + RND_HALF;
    sum_p = SUM_W'(p_ys_r) + SUM_W'(p_pc_r) + RND_HALF;
    sh_y  = sum_y >>> CS_FRAC;
    sh_p  = sum_p >>> CS_FRAC;
    if (p_locked_r) begin
      o_nxt.out_yaw   = clamp_axis(sh_y);
      o_nxt.out_pitch = clamp_axis(sh_p);
    end else begin
      o_nxt.out_yaw   = p_yaw_r;
      o_nxt.out_pitch = p_pitch_r;
    end
    o_nxt.locked = p_locked_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_r <= up_valid;
      end
      if (o_ready) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && up_valid) begin
      p_yc_r     <= yc_nxt;
      p_ps_r     <= ps_nxt;
      p_ys_r     <= ys_nxt;
      p_pc_r     <= pc_nxt;
      p_yaw_r    <= up_data.yaw;
      p_pitch_r  <= up_data.pitch;
      p_locked_r <= up_data.locked;
    end
    if (o_ready && p_valid_r) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_r;

  `LRSR_ASSERT_IMP(a_clamp_range, o_valid_r && o_r.locked, o_r.out_yaw <= POS_LIM_A && o_r.out_yaw >= NEG_LIM_A && o_r.out_pitch <= POS_LIM_A && o_r.out_pitch >= NEG_LIM_A, "locked result outside clamp range")

endmodule

// ----- sv/latched_roll_stick_rotator.sv -----
// Channel  | Handshake            | Payload                         | Role
// ---------+----------------------+---------------------------------+------------------------
// in_      | in_valid / in_ready  | in_data  (lrsr_in_t)            | stick, roll, buttons
// out_     | out_valid / out_ready| out_data (lrsr_out_t)           | corrected stick, locked
// cfg_     | cfg_we               | cfg_index, cfg_data             | enable, button_select
//
// One item per cycle sustained while out_ready is high; an accepted item reaches out_valid through
// 33 registers: one lock/angle stage, 30 rotator cells (one micro-rotation each), one
// product stage and the output register.
// rst_n is synchronous and active low; it clears the config registers, the lock and held roll,
// and every stage valid. No clearing pass is needed.
// Every stage holds while its successor is full and stalled; bubbles collapse, so
// in_ready drops only when all 33 stages hold items and out_ready is low.
`include "latched_roll_stick_rotator_assert.svh"

module latched_roll_stick_rotator #(
  parameter int ANGLE_BITS      = lrsr_pkg::ANGLE_BITS_DEF,
  parameter int STICK_FRAC_BITS = lrsr_pkg::STICK_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lrsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrsr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lrsr_pkg::lrsr_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lrsr_pkg::lrsr_out_t              out_data
);
  import lrsr_pkg::*;

  // Stage i feeds rotator cell i; the last stage feeds the multiply and clamp.
  lrsr_cell_t             st_data [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  st_valid;
  logic [CORDIC_STEPS:0]  st_ready;

  // Hold the lock state, capture roll on the press edge, fold the angle difference.
  lrsr_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .dn_valid  (st_valid[0]),
    .dn_ready  (st_ready[0]),
    .dn_data   (st_data[0])
  );

  // Advance cosine and sine one micro-rotation per cell.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : gen_cell
    lrsr_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up_data  (st_data[i]),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn_data  (st_data[i+1])
    );
  end

  // Rotate the stick while locked (else pass it through), round, clamp, and drive the result register.
  lrsr_mix #(
    .STICK_FRAC_BITS (STICK_FRAC_BITS)
  ) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (st_valid[CORDIC_STEPS]),
    .up_ready  (st_ready[CORDIC_STEPS]),
    .up_data   (st_data[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Input backs up only when the whole chain is full behind a stalled result.
  `LRSR_ASSERT_IMP(a_full_chain, !in_ready, out_valid && !out_ready && (&st_valid), "input stalled with room in the chain")

endmodule
